@@ rtl/aeg_pkg.sv @@
// Shared types, codes and time tables of the ADSR envelope generator.
package aeg_pkg;

	localparam int unsigned SAMPLE_RATE_DEFAULT = 44100;

	localparam int unsigned LEVEL_W = 32;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned NIB_N   = 16;

	localparam logic [LEVEL_W-1:0] ONE_Q31 = 32'h8000_0000;

	// Segment times in milliseconds, selected by a register nibble.
	localparam int unsigned ATTACK_MS [NIB_N] = '{
		2, 8, 16, 24, 38, 56, 68, 80,
		100, 250, 500, 800, 1000, 3000, 5000, 8000};

	localparam int unsigned FALL_MS [NIB_N] = '{
		6, 24, 48, 72, 114, 168, 204, 240,
		300, 750, 1500, 2400, 3000, 9000, 15000, 24000};

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_GATE_ON  = 3'd1,
		CMD_GATE_OFF = 3'd2,
		CMD_WRITE_AD = 3'd3,
		CMD_WRITE_SR = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	// Register nibbles as written by the two register commands.
	typedef struct packed {
		logic [NIB_W-1:0] attack;
		logic [NIB_W-1:0] decay;
		logic [NIB_W-1:0] sustain;
		logic [NIB_W-1:0] release_t;
	} nibs_t;

	// Step sizes and target level looked up from the nibbles, all Q1.31.
	typedef struct packed {
		logic [LEVEL_W-1:0] attack_step;
		logic [LEVEL_W-1:0] decay_step;
		logic [LEVEL_W-1:0] sustain_level;
		logic [LEVEL_W-1:0] release_step;
	} rate_set_t;

endpackage

@@ rtl/aeg_rate_rom.sv @@
// Constant tables: steps, sustain level per nibble; release step per nibble pair.
module aeg_rate_rom #(
	parameter int unsigned SAMPLE_RATE = aeg_pkg::SAMPLE_RATE_DEFAULT
) (
	input  aeg_pkg::nibs_t     nibs,
	output aeg_pkg::rate_set_t rates
);
	import aeg_pkg::*;

	localparam logic [63:0] NUM_Q31_MS = 64'h8000_0000 * 64'd1000;

	logic [LEVEL_W-1:0] atk_tbl [NIB_N];
	logic [LEVEL_W-1:0] dec_tbl [NIB_N];
	logic [LEVEL_W-1:0] sus_tbl [NIB_N];
	logic [LEVEL_W-1:0] rel_tbl [NIB_N*NIB_N];

	for (genvar i = 0; i < NIB_N; i++) begin : g_row
		localparam logic [63:0] ADEN = 64'(ATTACK_MS[i]) * 64'(SAMPLE_RATE);
		localparam logic [63:0] AQ   = (NUM_Q31_MS + ADEN / 2) / ADEN;
		localparam logic [63:0] FDEN = 64'(FALL_MS[i]) * 64'(SAMPLE_RATE);
		localparam logic [63:0] FQ   = (NUM_Q31_MS + FDEN / 2) / FDEN;
		localparam logic [63:0] SUS  = (64'(i) * 64'h8000_0000 + 64'd7) / 64'd15;

		assign atk_tbl[i] = (AQ > 64'(ONE_Q31)) ? ONE_Q31 : AQ[LEVEL_W-1:0];
		assign dec_tbl[i] = (FQ > 64'(ONE_Q31)) ? ONE_Q31 : FQ[LEVEL_W-1:0];
		assign sus_tbl[i] = SUS[LEVEL_W-1:0];

		for (genvar j = 0; j < NIB_N; j++) begin : g_col
			localparam logic [63:0] RDEN = 64'(FALL_MS[j]) * 64'(SAMPLE_RATE);
			localparam logic [63:0] RQ   = (NUM_Q31_MS + RDEN / 2) / RDEN;
			localparam logic [63:0] RSAT = (RQ > 64'(ONE_Q31)) ? 64'(ONE_Q31) : RQ;
			localparam logic [63:0] PROD = (SUS * RSAT + 64'h4000_0000) >> 31;

			assign rel_tbl[i*NIB_N+j] = PROD[LEVEL_W-1:0];
		end
	end

	assign rates.attack_step   = atk_tbl[nibs.attack];
	assign rates.decay_step    = dec_tbl[nibs.decay];
	assign rates.sustain_level = sus_tbl[nibs.sustain];
	assign rates.release_step  = rel_tbl[{nibs.sustain, nibs.release_t}];

endmodule

@@ rtl/aeg_env_core.sv @@
// Envelope state registers and the registered update for each command.
module aeg_env_core #(
	parameter int unsigned SAMPLE_RATE = aeg_pkg::SAMPLE_RATE_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  aeg_pkg::cmd_t               cmd,
	input  logic [7:0]                  value,
	output logic [aeg_pkg::LEVEL_W-1:0] level,
	output aeg_pkg::phase_t             phase
);
	import aeg_pkg::*;

	logic [LEVEL_W-1:0] level_q;
	logic [LEVEL_W-1:0] level_d;
	phase_t             phase_q;
	phase_t             phase_d;
	nibs_t              nibs_q;
	nibs_t              nibs_d;
	rate_set_t          rates;
	logic [LEVEL_W:0]   atk_sum;
	logic               dec_under;
	logic [LEVEL_W-1:0] dec_diff;
	logic               rel_under;

	aeg_rate_rom #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_rom (
		.nibs (nibs_q),
		.rates(rates)
	);

	assign atk_sum   = {1'b0, level_q} + {1'b0, rates.attack_step};
	assign dec_under = rates.decay_step >= level_q;
	assign dec_diff  = level_q - rates.decay_step;
	assign rel_under = rates.release_step >= level_q;

	always_comb begin
		level_d = level_q;
		phase_d = phase_q;
		nibs_d  = nibs_q;
		if (en) begin
			unique case (cmd)
				CMD_TICK: begin
					unique case (phase_q)
						PH_ATTACK: begin
							if (atk_sum >= {1'b0, ONE_Q31}) begin
								level_d = ONE_Q31;
								phase_d = PH_DECAY;
							end else begin
								level_d = atk_sum[LEVEL_W-1:0];
							end
						end
						PH_DECAY: begin
							// A level already under the target also lands on it.
							if (dec_under || dec_diff <= rates.sustain_level) begin
								level_d = rates.sustain_level;
								phase_d = PH_SUSTAIN;
							end else begin
								level_d = dec_diff;
							end
						end
						PH_RELEASE: begin
							if (rel_under) begin
								level_d = '0;
								phase_d = PH_IDLE;
							end else begin
								level_d = level_q - rates.release_step;
							end
						end
						default: begin
						end
					endcase
				end
				CMD_GATE_ON:  phase_d = PH_ATTACK;
				CMD_GATE_OFF: phase_d = PH_RELEASE;
				CMD_WRITE_AD: begin
					nibs_d.attack = value[7:4];
					nibs_d.decay  = value[3:0];
				end
				CMD_WRITE_SR: begin
					// Raising the sustain level while sustaining drops it to zero,
					// which also zeroes the release step through the table.
					if (phase_q == PH_SUSTAIN && value[7:4] > nibs_q.sustain) begin
						nibs_d.sustain = '0;
					end else begin
						nibs_d.sustain = value[7:4];
					end
					nibs_d.release_t = value[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			phase_q <= PH_IDLE;
			nibs_q  <= '0;
		end else begin
			level_q <= level_d;
			phase_q <= phase_d;
			nibs_q  <= nibs_d;
		end
	end

	assign level = level_q;
	assign phase = phase_q;

endmodule

@@ rtl/adsr_envelope_generator.sv @@
// ADSR envelope generator: one command in, the level and phase after it out.
// A command waits in the input register, then updates the envelope state that is the result.
// Throughput: one command per cycle unless the output stalls; the input register can take one
// more command while a result waits, and the whole update is one add or subtract and compare.
// Reset: arst_n clears the level to zero, the phase to idle and all register nibbles
// to zero at once; no clearing pass is needed.
module adsr_envelope_generator #(
	parameter int unsigned SAMPLE_RATE = aeg_pkg::SAMPLE_RATE_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] value
	input  logic [2:0]  s_tuser,   // [2:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] level, [34:32] phase, [39:35] zero
);
	import aeg_pkg::*;

	logic               valid_s1;
	logic [2:0]         cmd_s1;
	logic [7:0]         value_s1;
	logic               out_valid_q;
	logic               advance;
	logic               core_en;
	logic [LEVEL_W-1:0] level;
	phase_t             phase;

	// The envelope state doubles as the result register: it only moves when
	// the previous result has gone or is leaving in this cycle.
	assign advance  = !out_valid_q || m_tready;
	assign core_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			value_s1 <= s_tdata;
		end
	end

	aeg_env_core #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (core_en),
		.cmd   (cmd_t'(cmd_s1)),
		.value (value_s1),
		.level (level),
		.phase (phase)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, phase, level};

endmodule

@@ rtl/aeg_checker.sv @@
// Port-level checks on the envelope generator, bound to the top level.
module aeg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	import aeg_pkg::*;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:0] <= ONE_Q31)
		else $error("envelope level above full scale");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[34:32] == PH_IDLE) |-> m_tdata[31:0] == '0)
		else $error("idle phase with a non-zero level");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or vanished");

	a_decay_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tdata[34:32] == PH_ATTACK ##1
			m_tvalid && m_tdata[34:32] == PH_DECAY && $past(m_tdata[34:32]) == PH_ATTACK)
		|-> m_tdata[31:0] == ONE_Q31)
		else $error("decay entered from attack below full scale");

endmodule

bind adsr_envelope_generator aeg_checker u_aeg_checker (.*);
